>>> rtl/pwb_pkg.sv
// Shared widths, configuration register codes and pipeline sideband type for the warp core.
package pwb_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = 30;
    localparam int NUM_W     = 44;
    localparam int IPART_W   = QUO_W - FRAC_W;
    localparam int CFG_IDX_W = 3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_M00_M01    = 3'd0,
        CFG_M02_M10    = 3'd1,
        CFG_M11_M12    = 3'd2,
        CFG_M20_M21    = 3'd3,
        CFG_M22        = 3'd4,
        CFG_SRC_WIDTH  = 3'd5,
        CFG_SRC_HEIGHT = 3'd6
    } cfg_idx_t;

    // Per-item control traveling beside the datapath
    typedef struct packed {
        logic               valid;
        logic               mode;
        logic               wr_ok;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
        logic               degen;
        logic               off;
    } side_t;

endpackage

>>> rtl/pwb_ram.sv
// Generic single-port RAM with registered read data.
module pwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pwb_div.sv
// Pipelined restoring divider: one quotient bit per stage, fraction of a/b with a < b.
module pwb_div
    import pwb_pkg::*;
(
    input  logic             clk,
    input  logic             ce,
    input  logic [NUM_W-1:0] a,
    input  logic [NUM_W-1:0] b,
    output logic [QUO_W-1:0] q
);

    logic [NUM_W-1:0] r_reg [QUO_W-1];
    logic [NUM_W-1:0] b_reg [QUO_W-1];
    logic [QUO_W-1:0] q_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [NUM_W-1:0] r_in;
        logic [NUM_W-1:0] b_in;
        logic [QUO_W-1:0] q_in;
        logic [NUM_W:0]   sh;
        logic             take;

        if (k == 0)
        begin : g_first
            assign r_in = a;
            assign b_in = b;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign r_in = r_reg[k-1];
            assign b_in = b_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        // Shift remainder, subtract divisor when it fits
        assign sh   = {r_in, 1'b0};
        assign take = (sh >= {1'b0, b_in});

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                q_reg[k] <= {q_in[QUO_W-2:0], take};
            end
        end

        // Remainder and divisor are only needed by a following stage
        if (k < QUO_W - 1)
        begin : g_keep_b
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    r_reg[k] <= take ? NUM_W'(sh - {1'b0, b_in}) : sh[NUM_W-1:0];
                    b_reg[k] <= b_in;
                end
            end
        end
    end

    assign q = q_reg[QUO_W-1];

endmodule

>>> rtl/pwb_blend.sv
// Four-stage bilinear blend of four neighbor pixels with round-half-up.
module pwb_blend
    import pwb_pkg::*;
(
    input  logic              clk,
    input  logic              ce,
    input  logic [PIX_W-1:0]  v1,
    input  logic [PIX_W-1:0]  v2,
    input  logic [PIX_W-1:0]  v3,
    input  logic [PIX_W-1:0]  v4,
    input  logic [FRAC_W-1:0] fx,
    input  logic [FRAC_W-1:0] fy,
    output logic [PIX_W-1:0]  val
);

    localparam int WT_W = FRAC_W + 1;
    localparam int P_W  = PIX_W + WT_W;
    localparam int S_W  = P_W + 1;
    localparam int T_W  = S_W + WT_W;
    localparam logic [WT_W-1:0] ONE  = WT_W'(1) << FRAC_W;
    localparam logic [T_W:0]    HALF = (T_W+1)'(1) << (2*FRAC_W - 1);

    logic [WT_W-1:0] gx;
    logic [WT_W-1:0] gy;
    logic [P_W-1:0]  p1_reg, p2_reg, p3_reg, p4_reg;
    logic [WT_W-1:0] gy1_reg, fy1_reg, gy2_reg, fy2_reg;
    logic [S_W-1:0]  ra_reg, rb_reg;
    logic [T_W-1:0]  ta_reg, tb_reg;
    logic [T_W:0]    sum;
    logic [PIX_W-1:0] val_reg;

    assign gx = ONE - WT_W'(fx);
    assign gy = ONE - WT_W'(fy);

    // Horizontal weights
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg  <= P_W'(v1) * P_W'(gx);
            p2_reg  <= P_W'(v2) * P_W'(fx);
            p3_reg  <= P_W'(v3) * P_W'(gx);
            p4_reg  <= P_W'(v4) * P_W'(fx);
            gy1_reg <= gy;
            fy1_reg <= WT_W'(fy);
        end
    end

    // Row sums
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ra_reg  <= S_W'(p1_reg) + S_W'(p2_reg);
            rb_reg  <= S_W'(p3_reg) + S_W'(p4_reg);
            gy2_reg <= gy1_reg;
            fy2_reg <= fy1_reg;
        end
    end

    // Vertical weights
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ta_reg <= T_W'(ra_reg) * T_W'(gy2_reg);
            tb_reg <= T_W'(rb_reg) * T_W'(fy2_reg);
        end
    end

    // Add one half and drop the 32 fraction bits
    assign sum = (T_W+1)'(ta_reg) + (T_W+1)'(tb_reg) + HALF;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            val_reg <= sum[2*FRAC_W +: PIX_W];
        end
    end

    assign val = val_reg;

endmodule

>>> rtl/perspective_warp_bilinear_core.sv
// Homography warp core: banked source image store, projective mapping, bilinear blend.
// The core takes one item per clock when the sink does not stall and returns each query result
// after three mapping stages, a 30-stage one-bit-per-stage divider for each of x and y, an
// address stage, the image memory read and a four-stage blend, then the output register.
// A load writes its pixel at the same pipeline stage where queries read, so results always
// reflect every load accepted before the query. The source image sits in four banks split by
// column and row parity, so the four neighbors of a query are read in the same cycle. When the
// output item is held by the sink, the whole pipeline holds and input is not taken.
module perspective_warp_bilinear_core
    import pwb_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // coord_x[9:0], coord_y[19:10], pixel_in[27:20], zero
    input  logic [0:0]  s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // pixel_out[7:0]
    output logic [1:0]  m_axis_tuser,   // outside[0], degenerate[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int HW    = (MAX_WIDTH + 1) / 2;
    localparam int HH    = (MAX_HEIGHT + 1) / 2;
    localparam int BDEP  = HW * HH;
    localparam int BAW   = BDEP > 1 ? $clog2(BDEP) : 1;
    localparam int DIM_W = IPART_W + 1;

    // Bank address from half-resolution column and row
    function automatic logic [BAW-1:0] baddr(input logic [IPART_W-1:0] col,
                                             input logic [IPART_W-1:0] row);
        baddr = BAW'(int'(row) * HW + int'(col));
    endfunction

    // Configuration registers
    logic [63:0]        c0_reg, c1_reg, c2_reg, c3_reg;
    logic [31:0]        c4_reg;
    logic [COORD_W-1:0] sw_reg, sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= 64'h0001_0000_0000_0000;
            c1_reg <= '0;
            c2_reg <= 64'h0001_0000_0000_0000;
            c3_reg <= '0;
            c4_reg <= 32'h4000_0000;
            sw_reg <= COORD_W'(512);
            sh_reg <= COORD_W'(512);
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_M00_M01:    c0_reg <= cfg_data;
                CFG_M02_M10:    c1_reg <= cfg_data;
                CFG_M11_M12:    c2_reg <= cfg_data;
                CFG_M20_M21:    c3_reg <= cfg_data;
                CFG_M22:        c4_reg <= cfg_data[31:0];
                CFG_SRC_WIDTH:  sw_reg <= cfg_data[COORD_W-1:0];
                CFG_SRC_HEIGHT: sh_reg <= cfg_data[COORD_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    assign m00 = $signed(c0_reg[63:32]);
    assign m01 = $signed(c0_reg[31:0]);
    assign m02 = $signed(c1_reg[63:32]);
    assign m10 = $signed(c1_reg[31:0]);
    assign m11 = $signed(c2_reg[63:32]);
    assign m12 = $signed(c2_reg[31:0]);
    assign m20 = $signed(c3_reg[63:32]);
    assign m21 = $signed(c3_reg[31:0]);
    assign m22 = $signed(c4_reg);

    // Effective source size
    logic [DIM_W-1:0] weff, heff;
    assign weff = (int'(sw_reg) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : DIM_W'(sw_reg);
    assign heff = (int'(sh_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(sh_reg);

    // Pipeline advance and input unpacking
    logic               ce;
    logic               out_valid_reg;
    logic [COORD_W-1:0] in_x, in_y;
    side_t              in_side;

    assign ce            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;
    assign in_x          = s_axis_tdata[COORD_W-1:0];
    assign in_y          = s_axis_tdata[2*COORD_W-1:COORD_W];

    always_comb
    begin
        in_side       = '0;
        in_side.valid = s_axis_tvalid;
        in_side.mode  = s_axis_tuser[0];
        in_side.wr_ok = (int'(in_x) < MAX_WIDTH) && (int'(in_y) < MAX_HEIGHT);
        in_side.x     = in_x;
        in_side.y     = in_y;
        in_side.pix   = s_axis_tdata[2*COORD_W +: PIX_W];
    end

    // Stage 1: matrix products
    side_t              side1_reg;
    logic signed [42:0] px0_reg, py0_reg, px1_reg, py1_reg, px2_reg, py2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
        end
        else if (ce)
        begin
            side1_reg <= in_side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            px0_reg <= $signed({1'b0, in_x}) * m00;
            py0_reg <= $signed({1'b0, in_y}) * m01;
            px1_reg <= $signed({1'b0, in_x}) * m10;
            py1_reg <= $signed({1'b0, in_y}) * m11;
            px2_reg <= $signed({1'b0, in_x}) * m20;
            py2_reg <= $signed({1'b0, in_y}) * m21;
        end
    end

    // Stage 2: numerators and denominator
    side_t                   side2_reg;
    logic signed [NUM_W-1:0] nx_reg, ny_reg, den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side2_reg <= '0;
        end
        else if (ce)
        begin
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            nx_reg  <= NUM_W'(px0_reg) + NUM_W'(py0_reg) + NUM_W'(m02);
            ny_reg  <= NUM_W'(px1_reg) + NUM_W'(py1_reg) + NUM_W'(m12);
            den_reg <= NUM_W'(px2_reg) + NUM_W'(py2_reg) + NUM_W'(m22);
        end
    end

    // Stage 3: magnitudes, sign and zero checks
    side_t            side3_reg, side3, side3_next;
    logic [NUM_W-1:0] ax_reg, ay_reg, bd_reg;
    logic             negx, negy;

    assign negx = (nx_reg != '0) && (nx_reg[NUM_W-1] != den_reg[NUM_W-1]);
    assign negy = (ny_reg != '0) && (ny_reg[NUM_W-1] != den_reg[NUM_W-1]);

    always_comb
    begin
        side3_next       = side2_reg;
        side3_next.degen = (den_reg == '0);
        side3_next.off   = negx || negy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side3_reg <= '0;
        end
        else if (ce)
        begin
            side3_reg <= side3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ax_reg <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg)  : NUM_W'(nx_reg);
            ay_reg <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg)  : NUM_W'(ny_reg);
            bd_reg <= den_reg[NUM_W-1] ? NUM_W'(-den_reg) : NUM_W'(den_reg);
        end
    end

    // A quotient of one or more puts the point beyond any grid
    always_comb
    begin
        side3     = side3_reg;
        side3.off = side3_reg.off || (ax_reg >= bd_reg) || (ay_reg >= bd_reg);
    end

    // Dividers with sideband delay line
    logic [QUO_W-1:0] qx, qy;
    side_t            dside_reg [QUO_W];

    pwb_div u_div_x (.clk(clk), .ce(ce), .a(ax_reg), .b(bd_reg), .q(qx));
    pwb_div u_div_y (.clk(clk), .ce(ce), .a(ay_reg), .b(bd_reg), .q(qy));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                dside_reg[k] <= '0;
            end
        end
        else if (ce)
        begin
            dside_reg[0] <= side3;
            for (int k = 1; k < QUO_W; k++)
            begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // Stage 5: grid check and bank addresses
    side_t              s4;
    logic [IPART_W-1:0] ix, iy, col_e, col_o, row_e, row_o;
    logic               in_grid;
    logic [1:0]         wbank;
    logic [BAW-1:0]     waddr;
    logic [BAW-1:0]     addr5_next [4];
    logic [3:0]         we5_next;
    side_t              side5_next;

    assign s4      = dside_reg[QUO_W-1];
    assign ix      = qx[QUO_W-1:FRAC_W];
    assign iy      = qy[QUO_W-1:FRAC_W];
    assign in_grid = !s4.off && ((DIM_W'(ix) + DIM_W'(1)) < weff)
                             && ((DIM_W'(iy) + DIM_W'(1)) < heff);
    assign col_o   = ix >> 1;
    assign col_e   = (ix >> 1) + IPART_W'(ix[0]);
    assign row_o   = iy >> 1;
    assign row_e   = (iy >> 1) + IPART_W'(iy[0]);
    assign wbank   = {s4.y[0], s4.x[0]};
    assign waddr   = baddr(IPART_W'(s4.x >> 1), IPART_W'(s4.y >> 1));

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (s4.mode == MODE_LOAD)
            begin
                addr5_next[b] = waddr;
            end
            else
            begin
                addr5_next[b] = baddr(b[0] ? col_o : col_e, b[1] ? row_o : row_e);
            end
            we5_next[b] = s4.valid && (s4.mode == MODE_LOAD) && s4.wr_ok && (wbank == 2'(b));
        end
    end

    always_comb
    begin
        side5_next     = s4;
        side5_next.off = !in_grid;
    end

    side_t              side5_reg;
    logic [BAW-1:0]     addr5_reg [4];
    logic [3:0]         we5_reg;
    logic [PIX_W-1:0]   wdata5_reg;
    logic [FRAC_W-1:0]  fx5_reg, fy5_reg;
    logic               ix0_5_reg, iy0_5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side5_reg <= '0;
            we5_reg   <= '0;
        end
        else if (ce)
        begin
            side5_reg <= side5_next;
            we5_reg   <= we5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int b = 0; b < 4; b++)
            begin
                addr5_reg[b] <= addr5_next[b];
            end
            wdata5_reg <= s4.pix;
            fx5_reg    <= qx[FRAC_W-1:0];
            fy5_reg    <= qy[FRAC_W-1:0];
            ix0_5_reg  <= ix[0];
            iy0_5_reg  <= iy[0];
        end
    end

    // Image banks, indexed {row parity, column parity}
    logic [PIX_W-1:0] bank_q [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        pwb_ram #(.WIDTH(PIX_W), .DEPTH(BDEP)) u_ram (
            .clk   (clk),
            .en    (ce),
            .we    (we5_reg[b]),
            .addr  (addr5_reg[b]),
            .wdata (wdata5_reg),
            .rdata (bank_q[b])
        );
    end

    // Stage 6: memory data arrives; pick neighbors
    side_t             side6_reg;
    logic [FRAC_W-1:0] fx6_reg, fy6_reg;
    logic              ix0_6_reg, iy0_6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side6_reg <= '0;
        end
        else if (ce)
        begin
            side6_reg <= side5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fx6_reg   <= fx5_reg;
            fy6_reg   <= fy5_reg;
            ix0_6_reg <= ix0_5_reg;
            iy0_6_reg <= iy0_5_reg;
        end
    end

    logic [PIX_W-1:0] v1, v2, v3, v4, blend_val;

    assign v1 = bank_q[{iy0_6_reg,  ix0_6_reg}];
    assign v2 = bank_q[{iy0_6_reg, ~ix0_6_reg}];
    assign v3 = bank_q[{~iy0_6_reg,  ix0_6_reg}];
    assign v4 = bank_q[{~iy0_6_reg, ~ix0_6_reg}];

    pwb_blend u_blend (
        .clk (clk),
        .ce  (ce),
        .v1  (v1),
        .v2  (v2),
        .v3  (v3),
        .v4  (v4),
        .fx  (fx6_reg),
        .fy  (fy6_reg),
        .val (blend_val)
    );

    // Sideband alongside the blend stages
    side_t bside_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                bside_reg[k] <= '0;
            end
        end
        else if (ce)
        begin
            bside_reg[0] <= side6_reg;
            for (int k = 1; k < 4; k++)
            begin
                bside_reg[k] <= bside_reg[k-1];
            end
        end
    end

    // Output register: only queries produce an item
    logic [PIX_W-1:0] pix_out_reg;
    logic             outside_reg, degen_reg;
    side_t            sb;

    assign sb = bside_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= sb.valid && (sb.mode == MODE_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pix_out_reg <= (!sb.off && !sb.degen) ? blend_val : '0;
            outside_reg <= sb.off && !sb.degen;
            degen_reg   <= sb.degen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pix_out_reg;
    assign m_axis_tuser  = {degen_reg, outside_reg};

endmodule

>>> verif/pwb_checker.sv
// Checker for the warp core: tracks configuration and source image, predicts and compares results.
`timescale 1ns / 1ps

module pwb_checker
    import pwb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam int MAX_W = 512;
    localparam int MAX_H = 512;

    typedef struct packed {
        logic [7:0] pix;
        logic       outside;
        logic       degen;
    } warp_res_t;

    warp_res_t        due_q[$];
    logic [7:0]       src_img [0:MAX_W*MAX_H-1];
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [9:0]       src_w, src_h;
    int               n_loads, n_queries, n_outside, n_degen;

    initial
    begin
        errors    = 0;
        pending   = 0;
        n_loads   = 0;
        n_queries = 0;
        n_outside = 0;
        n_degen   = 0;
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // One axis: exact floor of num * 2^30 / den, on the grid if 0 <= its integer part (bits 29:16) < lim - 1
    function automatic bit axis_map(input longint num, input longint den, input int lim,
                                    output logic [13:0] ip, output logic [15:0] fr);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] q;
        a  = (num < 0) ? -num : num;
        b  = (den < 0) ? -den : den;
        ip = '0;
        fr = '0;
        if (a != 0 && ((num < 0) != (den < 0)))
            return 1'b0;
        if (a >= b)
            return 1'b0;
        q  = (a << 30) / b;
        ip = q[29:16];
        fr = q[15:0];
        return int'(ip) < lim - 1;
    endfunction

    // Projective mapping of an output coordinate into the source grid
    function automatic void land_point(input logic [9:0] x, input logic [9:0] y,
                                       output bit degen, output bit in_grid,
                                       output logic [13:0] ix, output logic [13:0] iy,
                                       output logic [15:0] fx, output logic [15:0] fy);
        longint xs, ys, nx, ny, den;
        int     w, h;
        xs  = x;
        ys  = y;
        nx  = xs * m00 + ys * m01 + m02;
        ny  = xs * m10 + ys * m11 + m12;
        den = xs * m20 + ys * m21 + m22;
        w   = (src_w > MAX_W) ? MAX_W : src_w;
        h   = (src_h > MAX_H) ? MAX_H : src_h;
        degen   = (den == 0);
        in_grid = 1'b0;
        ix = '0;
        iy = '0;
        fx = '0;
        fy = '0;
        if (!degen)
            in_grid = axis_map(nx, den, w, ix, fx) && axis_map(ny, den, h, iy, fy);
    endfunction

    function automatic warp_res_t warp_predict(input logic [9:0] x, input logic [9:0] y);
        warp_res_t   r;
        bit          degen, in_grid;
        logic [13:0] ix, iy;
        logic [15:0] fx, fy;
        logic [63:0] gx, gy, acc;
        int          base;
        r = '0;
        land_point(x, y, degen, in_grid, ix, iy, fx, fy);
        if (degen)
            r.degen = 1'b1;
        else if (!in_grid)
            r.outside = 1'b1;
        else
        begin
            base = int'(iy) * MAX_W + int'(ix);
            gx   = 64'd65536 - fx;
            gy   = 64'd65536 - fy;
            acc  = src_img[base] * gx * gy + src_img[base+1] * 64'(fx) * gy
                 + src_img[base+MAX_W] * gx * 64'(fy)
                 + src_img[base+MAX_W+1] * 64'(fx) * 64'(fy);
            acc  = (acc + 64'h8000_0000) >> 32;
            r.pix = acc[7:0];
        end
        return r;
    endfunction

    // Leftover expectations at the end of the run
    task automatic drain_check();
        if (due_q.size() != 0)
            report($sformatf("%0d results never arrived", due_q.size()));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        warp_res_t   got, want;
        logic [9:0]  x, y;
        if (!rst_n)
        begin
            m00   <= 32'sh0001_0000;
            m01   <= '0;
            m02   <= '0;
            m10   <= '0;
            m11   <= 32'sh0001_0000;
            m12   <= '0;
            m20   <= '0;
            m21   <= '0;
            m22   <= 32'sh4000_0000;
            src_w <= 10'd512;
            src_h <= 10'd512;
        end
        else
        begin
            // result side
            if (m_tvalid && m_tready)
            begin
                got = '{pix: m_tdata, outside: m_tuser[0], degen: m_tuser[1]};
                if (due_q.size() == 0)
                    report($sformatf("unexpected result pix=%0d", m_tdata));
                else
                begin
                    want = due_q.pop_front();
                    if (got.pix != want.pix)
                        report($sformatf("pixel_out %0d, want %0d", got.pix, want.pix));
                    if (got.outside != want.outside)
                        report($sformatf("outside %0b, want %0b", got.outside, want.outside));
                    if (got.degen != want.degen)
                        report($sformatf("degenerate %0b, want %0b", got.degen, want.degen));
                end
            end
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_M00_M01:    begin m00 <= cfg_data[63:32]; m01 <= cfg_data[31:0]; end
                    CFG_M02_M10:    begin m02 <= cfg_data[63:32]; m10 <= cfg_data[31:0]; end
                    CFG_M11_M12:    begin m11 <= cfg_data[63:32]; m12 <= cfg_data[31:0]; end
                    CFG_M20_M21:    begin m20 <= cfg_data[63:32]; m21 <= cfg_data[31:0]; end
                    CFG_M22:        m22   <= cfg_data[31:0];
                    CFG_SRC_WIDTH:  src_w <= cfg_data[9:0];
                    CFG_SRC_HEIGHT: src_h <= cfg_data[9:0];
                    default:        ;
                endcase
            end
            // input side
            if (s_tvalid && s_tready)
            begin
                x = s_tdata[9:0];
                y = s_tdata[19:10];
                if (s_tuser[0] == MODE_LOAD)
                begin
                    n_loads++;
                    if (x < MAX_W && y < MAX_H)
                        src_img[int'(y) * MAX_W + int'(x)] = s_tdata[27:20];
                end
                else
                begin
                    want = warp_predict(x, y);
                    n_queries++;
                    n_outside += want.outside;
                    n_degen   += want.degen;
                    due_q.push_back(want);
                end
            end
            pending = due_q.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the warp core: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import pwb_pkg::*;

    localparam int PATCH   = 12;    // side of the loaded source patch at the origin
    localparam int IMG_W   = 512;
    localparam int DRAIN   = 60;    // cycles waited once no result is pending
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;    // coord_x, coord_y, pixel_in, zero
    logic [0:0]           s_axis_tuser = '0;    // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // pixel_out
    logic [1:0]           m_axis_tuser;         // outside, degenerate
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    int                   errors, pending;

    bit loaded [0:IMG_W*IMG_W-1];
    int burst_left = 0;
    int rdy_mode = 0;
    int rdy_run = 0;
    bit rdy_state = 1'b1;
    bit diag_bias = 1'b0;

    perspective_warp_bilinear_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pwb_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: runs of ready and stall, lengths set by the current mode; mode 0 never stalls
    always @(posedge clk)
    begin
        if (rdy_run == 0)
        begin
            rdy_state = !rdy_state;
            case (rdy_mode)
                0:       begin rdy_state = 1'b1; rdy_run = 16; end
                1:       rdy_run = rdy_state ? $urandom_range(1, 12) : $urandom_range(1, 5);
                default: rdy_run = rdy_state ? $urandom_range(1, 3) : $urandom_range(1, 20);
            endcase
        end
        rdy_run--;
        m_axis_tready <= rdy_state;
    end

    // Sender: bursts of items separated by random gaps
    task automatic send_item(input logic md, input logic [9:0] x, input logic [9:0] y,
                             input logic [7:0] p);
        bit took;
        if (burst_left == 0)
        begin
            if (s_axis_tvalid)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, p, y, x};
        s_axis_tuser  <= md;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
        burst_left--;
        if (md == MODE_LOAD && x < IMG_W && y < IMG_W)
            loaded[int'(y) * IMG_W + int'(x)] = 1'b1;
    endtask

    // Wait until the core has drained, then past any loads still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] val);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic set_matrix(input logic [31:0] a00, a01, a02, a10, a11, a12, a20, a21,
                              input logic [31:0] a22, input logic [9:0] w, h);
        settle();
        cfg_write(CFG_M00_M01, {a00, a01});
        cfg_write(CFG_M02_M10, {a02, a10});
        cfg_write(CFG_M11_M12, {a11, a12});
        cfg_write(CFG_M20_M21, {a20, a21});
        cfg_write(CFG_M22, {$urandom, a22});
        cfg_write(CFG_SRC_WIDTH, {$urandom, 22'($urandom), w});
        cfg_write(CFG_SRC_HEIGHT, {$urandom, 22'($urandom), h});
        cfg_valid <= 1'b0;
    endtask

    // A query is usable if it never touches a pixel that was not loaded
    function automatic bit query_safe(input logic [9:0] x, input logic [9:0] y);
        bit          degen, in_grid;
        logic [13:0] ix, iy;
        logic [15:0] fx, fy;
        int          base;
        chk.land_point(x, y, degen, in_grid, ix, iy, fx, fy);
        if (degen || !in_grid)
            return 1'b1;
        base = int'(iy) * IMG_W + int'(ix);
        return loaded[base] && loaded[base+1] && loaded[base+IMG_W] && loaded[base+IMG_W+1];
    endfunction

    function automatic logic [9:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 10'($urandom_range(0, 3));
        if (r < 30)
            return 10'($urandom_range(1020, 1023));
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic rand_query();
        logic [9:0] x, y;
        int         k;
        for (k = 0; k < 10; k++)
        begin
            x = rand_coord();
            y = (diag_bias && $urandom_range(0, 4) == 0) ? x : rand_coord();
            if (query_safe(x, y))
            begin
                send_item(MODE_QUERY, x, y, 8'($urandom));
                return;
            end
        end
        send_item(MODE_LOAD, 10'($urandom_range(0, PATCH - 1)),
                  10'($urandom_range(0, PATCH - 1)), 8'($urandom));
    endtask

    // Mixed traffic: patch loads, stray loads, and queries
    task automatic run_traffic(input int n);
        int i, r;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                send_item(MODE_LOAD, 10'($urandom_range(0, PATCH - 1)),
                          10'($urandom_range(0, PATCH - 1)), 8'($urandom));
            else if (r < 32)
                send_item(MODE_LOAD, 10'($urandom), 10'($urandom), 8'($urandom));
            else
                rand_query();
        end
    endtask

    // Signed value from lo to hi inclusive
    function automatic logic [31:0] srand(input int lo, input int hi);
        return 32'($signed(lo) + $signed($urandom_range(0, hi - lo)));
    endfunction

    initial
    begin
        int i, j;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity mapping, corners of the full-size grid
        send_item(MODE_LOAD, 10'd0, 10'd0, 8'd0);
        send_item(MODE_LOAD, 10'd1, 10'd0, 8'd255);
        send_item(MODE_LOAD, 10'd0, 10'd1, 8'd170);
        send_item(MODE_LOAD, 10'd1, 10'd1, 8'd85);
        send_item(MODE_LOAD, 10'd510, 10'd510, 8'd255);
        send_item(MODE_LOAD, 10'd511, 10'd510, 8'd1);
        send_item(MODE_LOAD, 10'd510, 10'd511, 8'd128);
        send_item(MODE_LOAD, 10'd511, 10'd511, 8'd254);
        send_item(MODE_LOAD, 10'd1023, 10'd1023, 8'd255);  // ignored, off the store
        send_item(MODE_LOAD, 10'd512, 10'd3, 8'd77);       // ignored, off the store
        send_item(MODE_QUERY, 10'd0, 10'd0, 8'd255);
        send_item(MODE_QUERY, 10'd510, 10'd510, 8'd0);
        send_item(MODE_QUERY, 10'd511, 10'd511, 8'd0);     // last column and row
        send_item(MODE_QUERY, 10'd511, 10'd0, 8'd0);
        send_item(MODE_QUERY, 10'd0, 10'd511, 8'd0);
        send_item(MODE_QUERY, 10'd1023, 10'd1023, 8'd0);

        // Zero denominator
        set_matrix(ONE_Q16, 0, 0, 0, ONE_Q16, 0, 0, 0, 0, 10'd512, 10'd512);
        send_item(MODE_QUERY, 10'd5, 10'd5, 8'd0);
        send_item(MODE_QUERY, 10'd0, 10'd0, 8'd0);

        // Negative source coordinate: shift left by half a pixel
        set_matrix(ONE_Q16, 0, -32'sh8000, 0, ONE_Q16, 0, 0, 0, ONE_Q30, 10'd512, 10'd512);
        send_item(MODE_QUERY, 10'd0, 10'd0, 8'd0);
        send_item(MODE_QUERY, 10'd1, 10'd0, 8'd0);

        // Phase A: small image, affine mapping without perspective, fill the patch first
        rdy_mode = 0;
        set_matrix(srand(0, 1100), srand(0, 200), srand(-65536, 4 * 65536), srand(0, 200),
                   srand(0, 1100), srand(-65536, 4 * 65536), 0, 0, ONE_Q30,
                   10'(PATCH), 10'(PATCH));
        for (i = 0; i < PATCH; i++)
            for (j = 0; j < PATCH; j++)
                send_item(MODE_LOAD, 10'(j), 10'(i), 8'($urandom));
        run_traffic(90);

        // Phase B: wide and flat, with perspective
        rdy_mode = 1;
        set_matrix(srand(-200, 1100), srand(-200, 400), srand(-65536, 65536 * 8),
                   srand(-100, 100), srand(0, 300), srand(-65536, 65536),
                   srand(-262144, 262144), srand(-262144, 262144),
                   srand(32'sh3800_0000, 32'sh4800_0000), 10'd512, 10'd2);
        run_traffic(90);

        // Phase C: narrow and tall, heavy receiver stalls
        rdy_mode = 2;
        set_matrix(srand(0, 300), srand(-100, 100), srand(-65536, 65536),
                   srand(-200, 400), srand(-200, 1100), srand(-65536, 65536 * 8),
                   srand(-262144, 262144), srand(-262144, 262144),
                   srand(32'sh3800_0000, 32'sh4800_0000), 10'd2, 10'd512);
        run_traffic(90);

        // Phase D: raw random coefficients, oversized width with zero height, then width one with oversized height
        rdy_mode = 1;
        set_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, 10'd1023, 10'd0);
        run_traffic(80);
        set_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, 10'd1, 10'd1023);
        run_traffic(40);

        // Phase E: negative denominator, negated numerators
        rdy_mode = 0;
        set_matrix(-srand(0, 1100), -srand(0, 200), -srand(-65536, 4 * 65536),
                   -srand(0, 200), -srand(0, 1100), -srand(-65536, 4 * 65536),
                   -srand(-100000, 100000), -srand(-100000, 100000), -ONE_Q30,
                   10'(PATCH), 10'(PATCH));
        run_traffic(90);

        // Phase F: denominator zero along the diagonal
        rdy_mode = 2;
        diag_bias = 1'b1;
        set_matrix(srand(0, 1100), 0, srand(0, 65536), 0, srand(0, 1100), srand(0, 65536),
                   32'sh0010_0000, -32'sh0010_0000, 0, 10'(PATCH), 10'(PATCH));
        run_traffic(90);

        settle();
        chk.drain_check();
        $display("Covered %0d loads and %0d queries, %0d off the grid, %0d degenerate,",
                 chk.n_loads, chk.n_queries, chk.n_outside, chk.n_degen);
        $display("over directed corners and seven random matrix and size settings.");
        if (errors == 0)
            $display("perspective_warp_bilinear_core regression: pass");
        else
            $display("perspective_warp_bilinear_core regression: fail");
        $finish;
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("perspective_warp_bilinear_core regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pwb_pkg.sv
rtl/pwb_ram.sv
rtl/pwb_div.sv
rtl/pwb_blend.sv
rtl/perspective_warp_bilinear_core.sv
verif/pwb_checker.sv
verif/tb_top.sv
